>>> rtl/assert_macros.svh
// Assertion macros used by the checker file rbsi_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBSI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/rbsi_pkg.sv
// Types and constants of the ray versus box slab test.
// No dependencies; used by every rbsi module and the top level.
package rbsi_pkg;

  localparam int COORD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIST_W        = 31;
  localparam int NUM_W         = COORD_W + 2;
  localparam int MAG_W         = COORD_W + 1;
  localparam int CMP_W         = (COORD_W - 1 > DIST_W) ? COORD_W - 1 : DIST_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-2:0]        half_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [COORD_W-1:0]        den_t;
  typedef logic [DIST_W-1:0]         dist_t;

  localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
  localparam dist_t  DIST_MAX  = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_HALF_X   = 3'd3,
    REG_HALF_Y   = 3'd4,
    REG_HALF_Z   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    dist_t  max_distance;
  } ray_t;

  typedef struct packed {
    logic  hit;
    dist_t distance;
  } result_t;

  typedef struct packed {
    coord_t [2:0] center;
    half_t  [2:0] half;
  } box_t;

  typedef struct packed {
    num_t   [2:0] lo;
    num_t   [2:0] hi;
    coord_t [2:0] dir;
    dist_t        limit;
  } sa_t;

  typedef struct packed {
    mag_t [2:0] alo;
    mag_t [2:0] ahi;
    den_t [2:0] ad;
    logic [2:0] nlo;
    logic [2:0] nhi;
    logic [2:0] dzero;
    logic [2:0] in_slab;
    dist_t      limit;
  } sb_t;

  typedef struct packed {
    den_t               den;
    den_t               rem;
    logic [COORD_W-2:0] low;
    logic [COORD_W-2:0] quo;
    logic               neg;
    logic               ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [5:0] lane;
    logic [2:0]      dzero;
    logic [2:0]      in_slab;
    dist_t           limit;
  } div_item_t;

  typedef struct packed {
    coord_t [5:0] t;
    logic [2:0]   dzero;
    logic [2:0]   in_slab;
    dist_t        limit;
  } be_t;

  typedef struct packed {
    coord_t [2:0] tmin;
    coord_t [2:0] tmax;
    logic         ok;
    dist_t        limit;
  } bf_t;

  typedef struct packed {
    coord_t enter;
    coord_t leave;
    logic   ok;
    dist_t  limit;
  } bg_t;

endpackage

>>> rtl/rbsi_front.sv
// Front stages: slab face offsets, magnitudes and signs, divider setup.
// Depends on rbsi_pkg.
module rbsi_front #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rbsi_pkg::box_t       box,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbsi_pkg::ray_t       in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rbsi_pkg::div_item_t  out_item
);
  localparam int CW    = rbsi_pkg::COORD_W;
  localparam int NW    = rbsi_pkg::NUM_W;
  localparam int MW    = rbsi_pkg::MAG_W;
  localparam int SHIFT = CW - 1 - FRAC_BITS;

  rbsi_pkg::coord_t [2:0] org;
  rbsi_pkg::coord_t [2:0] dir;
  rbsi_pkg::sa_t          a, a_next;
  rbsi_pkg::sb_t          b, b_next;
  rbsi_pkg::div_item_t    c_next;
  logic                   a_valid, b_valid, c_valid;
  logic                   a_ready, b_ready, c_ready;
  rbsi_pkg::mag_t         m, rinit;

  assign org = {in_item.origin_z, in_item.origin_y, in_item.origin_x};
  assign dir = {in_item.dir_z, in_item.dir_y, in_item.dir_x};

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    a_next = '0;
    for (int i = 0; i < 3; i++) begin
      a_next.lo[i] = NW'($signed(box.center[i])) - NW'(box.half[i]) - NW'($signed(org[i]));
      a_next.hi[i] = NW'($signed(box.center[i])) + NW'(box.half[i]) - NW'($signed(org[i]));
      a_next.dir[i] = dir[i];
    end
    a_next.limit = in_item.max_distance;
  end

  always_comb begin
    b_next = '0;
    for (int i = 0; i < 3; i++) begin
      b_next.alo[i]     = MW'(a.lo[i][NW-1] ? -a.lo[i] : a.lo[i]);
      b_next.ahi[i]     = MW'(a.hi[i][NW-1] ? -a.hi[i] : a.hi[i]);
      b_next.ad[i]      = a.dir[i][CW-1] ? -a.dir[i] : a.dir[i];
      b_next.nlo[i]     = a.lo[i][NW-1] ^ a.dir[i][CW-1];
      b_next.nhi[i]     = a.hi[i][NW-1] ^ a.dir[i][CW-1];
      b_next.dzero[i]   = (a.dir[i] == '0);
      b_next.in_slab[i] = (a.lo[i][NW-1] || a.lo[i] == '0) && !a.hi[i][NW-1];
    end
    b_next.limit = a.limit;
  end

  always_comb begin
    c_next = '0;
    m      = '0;
    rinit  = '0;
    for (int k = 0; k < 6; k++) begin
      m     = (k % 2 == 0) ? b.alo[k/2] : b.ahi[k/2];
      rinit = m >> SHIFT;
      c_next.lane[k].den = b.ad[k/2];
      c_next.lane[k].rem = CW'(rinit);
      c_next.lane[k].low = (CW-1)'(m << FRAC_BITS);
      c_next.lane[k].quo = '0;
      c_next.lane[k].neg = (k % 2 == 0) ? b.nlo[k/2] : b.nhi[k/2];
      c_next.lane[k].ovf = (rinit >= MW'(b.ad[k/2]));
    end
    c_next.dzero   = b.dzero;
    c_next.in_slab = b.in_slab;
    c_next.limit   = b.limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) a <= a_next;
    if (b_ready) b <= b_next;
    if (c_ready) out_item <= c_next;
  end

  assign out_valid = c_valid;

endmodule

>>> rtl/rbsi_div_step.sv
// One restoring division step for all six slab quotients.
// Depends on rbsi_pkg.
module rbsi_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbsi_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rbsi_pkg::div_item_t out_item
);
  localparam int CW = rbsi_pkg::COORD_W;

  rbsi_pkg::div_item_t item_next;
  logic [CW:0]         rs;
  logic                ge;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    item_next = in_item;
    rs = '0;
    ge = 1'b0;
    for (int k = 0; k < 6; k++) begin
      rs = {in_item.lane[k].rem, in_item.lane[k].low[CW-2]};
      ge = (rs >= {1'b0, in_item.lane[k].den});
      item_next.lane[k].rem = ge ? CW'(rs - {1'b0, in_item.lane[k].den}) : CW'(rs);
      item_next.lane[k].low = {in_item.lane[k].low[CW-3:0], 1'b0};
      item_next.lane[k].quo = {in_item.lane[k].quo[CW-3:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_item <= item_next;
  end

endmodule

>>> rtl/rbsi_back.sv
// Back stages: signed saturated distances, slab ordering, entry/exit, result.
// Depends on rbsi_pkg.
module rbsi_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbsi_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rbsi_pkg::result_t   out_item
);
  localparam int CW = rbsi_pkg::COORD_W;

  rbsi_pkg::be_t     e, e_next;
  rbsi_pkg::bf_t     f, f_next;
  rbsi_pkg::bg_t     g, g_next;
  rbsi_pkg::result_t h_next;
  logic              e_valid, f_valid, g_valid;
  logic              e_ready, f_ready, g_ready, h_ready;
  rbsi_pkg::coord_t  q, t0, t1, lo, hi, m0, m1, x0;
  logic [CW-2:0]     ent_u;
  logic              hit;

  assign h_ready  = !out_valid || out_ready;
  assign g_ready  = !g_valid || h_ready;
  assign f_ready  = !f_valid || g_ready;
  assign e_ready  = !e_valid || f_ready;
  assign in_ready = e_ready;

  always_comb begin
    e_next = '0;
    q      = '0;
    for (int k = 0; k < 6; k++) begin
      q = rbsi_pkg::coord_t'({1'b0, in_item.lane[k].quo});
      if (in_item.lane[k].ovf) begin
        e_next.t[k] = in_item.lane[k].neg ? rbsi_pkg::COORD_MIN : rbsi_pkg::COORD_MAX;
      end else begin
        e_next.t[k] = in_item.lane[k].neg ? -q : q;
      end
    end
    e_next.dzero   = in_item.dzero;
    e_next.in_slab = in_item.in_slab;
    e_next.limit   = in_item.limit;
  end

  always_comb begin
    f_next = '0;
    t0 = '0;
    t1 = '0;
    lo = '0;
    hi = '0;
    for (int i = 0; i < 3; i++) begin
      t0 = e.t[2*i];
      t1 = e.t[2*i+1];
      lo = ($signed(t0) > $signed(t1)) ? t1 : t0;
      hi = ($signed(t0) > $signed(t1)) ? t0 : t1;
      f_next.tmin[i] = e.dzero[i] ? '0 : lo;
      f_next.tmax[i] = e.dzero[i] ? rbsi_pkg::COORD_MAX : hi;
    end
    f_next.ok    = &(~e.dzero | e.in_slab);
    f_next.limit = e.limit;
  end

  always_comb begin
    g_next = '0;
    m0 = ($signed(f.tmin[0]) > $signed(f.tmin[1])) ? f.tmin[0] : f.tmin[1];
    m1 = ($signed(f.tmin[2]) > 0) ? f.tmin[2] : '0;
    x0 = ($signed(f.tmax[0]) < $signed(f.tmax[1])) ? f.tmax[0] : f.tmax[1];
    g_next.enter = ($signed(m0) > $signed(m1)) ? m0 : m1;
    g_next.leave = ($signed(x0) < $signed(f.tmax[2])) ? x0 : f.tmax[2];
    g_next.ok    = f.ok;
    g_next.limit = f.limit;
  end

  always_comb begin
    ent_u = g.enter[CW-2:0];
    hit = g.ok && !($signed(g.enter) > $signed(g.leave))
        && (g.limit == '0
            || rbsi_pkg::CMP_W'(ent_u) < rbsi_pkg::CMP_W'(g.limit));
    h_next.hit = hit;
    if (!hit) begin
      h_next.distance = '0;
    end else if (rbsi_pkg::CMP_W'(ent_u) > rbsi_pkg::CMP_W'(rbsi_pkg::DIST_MAX)) begin
      h_next.distance = rbsi_pkg::DIST_MAX;
    end else begin
      h_next.distance = rbsi_pkg::DIST_W'(ent_u);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (e_ready) e_valid   <= in_valid;
      if (f_ready) f_valid   <= e_valid;
      if (g_ready) g_valid   <= f_valid;
      if (h_ready) out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) e <= e_next;
    if (f_ready) f <= f_next;
    if (g_ready) g <= g_next;
    if (h_ready) out_item <= h_next;
  end

endmodule

>>> rtl/ray_box_slab_intersect.sv
// Channel  | Signals                           | Direction
// ray      | ray_valid, ray_stall, ray         | in (ray_stall out)
// result   | result_valid, result_stall, result| out (result_stall in)
// cfg      | cfg_we, cfg_index, cfg_data       | in
// One ray per cycle while no stall holds the pipeline (ray_stall high shows a stall).
// The restoring divider yields one quotient bit per stage.
// Reset is synchronous; it empties the pipeline and clears the box to zero.
// A stalled result holds only the stages behind it; bubbles are squeezed out.
// Top level of the ray versus box slab test; depends on rbsi_pkg, rbsi_front, rbsi_div_step and rbsi_back.
module ray_box_slab_intersect #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbsi_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               ray_valid,
  output logic                               ray_stall,
  input  rbsi_pkg::ray_t                     ray,
  output logic                               result_valid,
  input  logic                               result_stall,
  output rbsi_pkg::result_t                  result
);
  localparam int CW     = rbsi_pkg::COORD_W;
  localparam int STEPS  = CW - 1;

  rbsi_pkg::box_t      box;
  logic                front_ready;
  logic [STEPS:0]      dv;
  logic [STEPS:0]      dr;
  rbsi_pkg::div_item_t di [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (cfg_we) begin
      unique case (rbsi_pkg::cfg_reg_e'(cfg_index))
        rbsi_pkg::REG_CENTER_X: box.center[0] <= cfg_data[CW-1:0];
        rbsi_pkg::REG_CENTER_Y: box.center[1] <= cfg_data[CW-1:0];
        rbsi_pkg::REG_CENTER_Z: box.center[2] <= cfg_data[CW-1:0];
        rbsi_pkg::REG_HALF_X:   box.half[0]   <= cfg_data[CW-2:0];
        rbsi_pkg::REG_HALF_Y:   box.half[1]   <= cfg_data[CW-2:0];
        rbsi_pkg::REG_HALF_Z:   box.half[2]   <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  assign ray_stall = !front_ready;

  rbsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .box       (box),
    .in_valid  (ray_valid),
    .in_ready  (front_ready),
    .in_item   (ray),
    .out_valid (dv[0]),
    .out_ready (dr[0]),
    .out_item  (di[0])
  );

  for (genvar s = 0; s < STEPS; s++) begin : g_div
    rbsi_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[s]),
      .in_ready  (dr[s]),
      .in_item   (di[s]),
      .out_valid (dv[s+1]),
      .out_ready (dr[s+1]),
      .out_item  (di[s+1])
    );
  end

  rbsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[STEPS]),
    .in_ready  (dr[STEPS]),
    .in_item   (di[STEPS]),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .out_item  (result)
  );

endmodule

>>> rtl/rbsi_checker.sv
// Port-level checks of the ray versus box slab test, bound to the top level.
// Depends on rbsi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rbsi_checker (
  input logic              clk,
  input logic              rst,
  input logic              ray_stall,
  input logic              result_valid,
  input logic              result_stall,
  input rbsi_pkg::result_t result
);

  `RBSI_ASSERT_NEXT(a_res_hold, clk, rst, result_valid && result_stall, result_valid)
  `RBSI_ASSERT_NEXT(a_res_stable, clk, rst, result_valid && result_stall, $stable(result))
  `RBSI_ASSERT_NOW(a_miss_zero, clk, rst, result_valid && !result.hit, result.distance == '0)
  `RBSI_ASSERT_NOW(a_flow, clk, rst, !result_stall, !ray_stall)

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for ray_box_slab_intersect: rays in, hit/distance out.
// Depends on rbsi_pkg and the RTL top level; predicts each result with a slab-method model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic ray_valid, ray_stall;
  ray_t ray;
  logic result_valid, result_stall;
  result_t result;

  ray_box_slab_intersect uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint Q_TOP = 64'sd2147483647;
  localparam longint Q_BOT = -64'sd2147483648;

  ray_t    ray_queue[$];
  result_t hit_queue[$];
  longint  box_center[3];
  longint  box_half[3];
  int      tx_idle, rx_idle;
  int      fails;
  int      stale;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint slab_quot(longint num, longint den);
    bit neg;
    longint an, ad, qi, mag;
    neg = (num < 0) != (den < 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    qi = an / ad;
    if (qi > 32768) mag = 64'sd2147483648;
    else mag = (an <<< 16) / ad;
    if (neg) return (mag >= 64'sd2147483648) ? Q_BOT : -mag;
    return (mag > Q_TOP) ? Q_TOP : mag;
  endfunction

  function automatic result_t predict_hit(ray_t r);
    longint org[3], dir[3];
    longint lo, hi, t0, t1, s, enter, leave;
    bit bounded, ok;
    result_t res;
    org[0] = longint'(r.origin_x); org[1] = longint'(r.origin_y);
    org[2] = longint'(r.origin_z);
    dir[0] = longint'(r.dir_x); dir[1] = longint'(r.dir_y); dir[2] = longint'(r.dir_z);
    enter = 0; leave = 0; bounded = 0; ok = 1;
    for (int a = 0; a < 3; a++) begin
      lo = box_center[a] - box_half[a];
      hi = box_center[a] + box_half[a];
      if (dir[a] == 0) begin
        if (!(lo <= org[a] && org[a] <= hi)) ok = 0;
      end else begin
        t0 = slab_quot(lo - org[a], dir[a]);
        t1 = slab_quot(hi - org[a], dir[a]);
        if (t0 > t1) begin
          s = t0; t0 = t1; t1 = s;
        end
        if (t0 > enter) enter = t0;
        if (!bounded || t1 < leave) leave = t1;
        bounded = 1;
      end
    end
    if (ok && bounded && enter > leave) ok = 0;
    if (ok && r.max_distance != 0 && enter >= longint'({1'b0, r.max_distance})) ok = 0;
    res.hit = ok;
    res.distance = ok ? dist_t'(enter > Q_TOP ? Q_TOP : enter) : '0;
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      ray_valid <= 1'b0;
    end else begin
      if (ray_valid && !ray_stall) hit_queue.push_back(predict_hit(ray));
      if (!ray_valid || !ray_stall) begin
        if (ray_queue.size() > 0 && $urandom_range(99) >= tx_idle) begin
          ray <= ray_queue.pop_front();
          ray_valid <= 1'b1;
        end else begin
          ray_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_res;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle);
      if (result_valid && !result_stall) begin
        if (hit_queue.size() == 0) begin
          $error("result with no expectation: hit %0b distance %0h", result.hit,
                 result.distance);
          fails++;
        end else begin
          exp_res = hit_queue.pop_front();
          if (result.hit !== exp_res.hit) begin
            $error("hit: expected %0b actual %0b", exp_res.hit, result.hit);
            fails++;
          end
          if (result.distance !== exp_res.distance) begin
            $error("distance: expected %0h actual %0h", exp_res.distance, result.distance);
            fails++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (ray_valid && !ray_stall) || (result_valid && !result_stall) ||
        (ray_queue.size() == 0 && hit_queue.size() == 0 && !ray_valid)) begin
      stale <= 0;
    end else begin
      stale <= stale + 1;
      if (stale >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx <= REG_CENTER_Z) box_center[int'(idx)] = longint'($signed(v));
    else box_half[int'(idx) - 3] = longint'({33'd0, v[30:0]});
  endtask

  task automatic load_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_HALF_X, hx);
    write_reg(REG_HALF_Y, hy);
    write_reg(REG_HALF_Z, hz);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (ray_queue.size() > 0 || hit_queue.size() > 0 || ray_valid) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic ray_t mk_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                  logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                  logic [30:0] lim);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.max_distance = lim;
    return r;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > Q_TOP) return COORD_MAX;
    if (v < Q_BOT) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // aim the ray from a random origin around the box centre at a random point inside it
  function automatic ray_t aimed_ray();
    longint tgt, org, d;
    coord_t o3[3], d3[3];
    int sh;
    ray_t r;
    sh = $urandom_range(4);
    for (int a = 0; a < 3; a++) begin
      tgt = box_center[a] + (longint'($urandom) % (box_half[a] + 1)) *
            ($urandom_range(1) ? 1 : -1);
      org = box_center[a] + longint'($signed($urandom)) / 64;
      o3[a] = clamp_coord(org);
      d = (tgt - longint'(o3[a])) >>> sh;
      if ($urandom_range(15) == 0) d = 0;
      d3[a] = clamp_coord(d);
    end
    r = mk_ray(o3[0], o3[1], o3[2], d3[0], d3[1], d3[2], 31'd0);
    case ($urandom_range(3))
      0: r.max_distance = '0;
      1: r.max_distance = 31'($urandom);
      2: r.max_distance = 31'($urandom_range(1 << 20));
      default: r.max_distance = 31'($urandom_range(1 << 17));
    endcase
    return r;
  endfunction

  function automatic ray_t noise_ray();
    return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  31'($urandom));
  endfunction

  initial begin
    int nrand;
    fails = 0;
    tx_idle = 0;
    rx_idle = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ray_valid = 1'b0;
    ray = '0;
    result_stall = 1'b0;
    for (int a = 0; a < 3; a++) begin
      box_center[a] = 0;
      box_half[a] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // point box at the origin after reset
    ray_queue.push_back(mk_ray(0, 0, 0, 0, 0, 0, 0));
    ray_queue.push_back(mk_ray(1, 0, 0, 0, 0, 0, 0));
    ray_queue.push_back(mk_ray(-65536, 0, 0, 65536, 0, 0, 0));
    drain();

    load_box(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
             32'h0000_8000, 32'h0001_0000, 32'h0000_4000);
    ray_queue.push_back(mk_ray(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0));
    ray_queue.push_back(mk_ray(32'h0001_8000, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0));
    ray_queue.push_back(mk_ray(32'h0001_8001, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0));
    ray_queue.push_back(mk_ray(0, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0));
    ray_queue.push_back(mk_ray(0, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_0000, 0, 0, 0));
    ray_queue.push_back(mk_ray(0, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 0,
                               31'h0000_8000));
    ray_queue.push_back(mk_ray(0, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 0,
                               31'h0000_8001));
    ray_queue.push_back(mk_ray(0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                               32'h0001_0000, 0, 0));
    ray_queue.push_back(mk_ray(0, 0, 0, 1, 1, 1, 0));
    ray_queue.push_back(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h8000_0000, 1, 31'h7FFF_FFFF));
    ray_queue.push_back(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd1));
    ray_queue.push_back(mk_ray(0, 32'h0002_0000, 32'hFFFF_0000, 1, 0, 0, 0));
    drain();

    load_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF);
    ray_queue.push_back(mk_ray(0, 0, 0, 1, 1, 1, 0));
    ray_queue.push_back(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'hFFFF_FFFF, 0, 0));
    ray_queue.push_back(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin tx_idle = 0;  rx_idle = 0;  end
        1: begin tx_idle = 71; rx_idle = 0;  end
        2: begin tx_idle = 0;  rx_idle = 71; end
        default: begin tx_idle = 38; rx_idle = 38; end
      endcase
      case (ph)
        3: load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        5: load_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        6: load_box(0, 0, 0, $urandom_range(1 << 16), 0, $urandom_range(1 << 16));
        default: load_box($signed($urandom) / 128, $signed($urandom) / 128,
                          $signed($urandom) / 128, $urandom_range(1 << 22),
                          $urandom_range(1 << 22), $urandom_range(1 << 22));
      endcase
      nrand = 0;
      while (nrand < 228) begin
        if ($urandom_range(9) < 8) ray_queue.push_back(aimed_ray());
        else ray_queue.push_back(noise_ray());
        nrand++;
        // stop queueing rays once until all queued rays are sent and their results are back
        if (ph == 1 && nrand == 114) begin
          while (ray_queue.size() > 0 || hit_queue.size() > 0 || ray_valid) @(posedge clk);
        end
      end
      drain();
    end

    if (fails == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/rbsi_pkg.sv
rtl/rbsi_front.sv
rtl/rbsi_div_step.sv
rtl/rbsi_back.sv
rtl/ray_box_slab_intersect.sv
rtl/rbsi_checker.sv
sim/tb_top.sv
